// ===== hdl/glrt_pkg.sv =====
// ----------------------------------------------------------------------------
// glrt_pkg: shared types and constants of the grid line regularity tracker
// Widths, sentinel window, register indexes and sequencer encodings.
// ----------------------------------------------------------------------------
package glrt_pkg;

   localparam int COORD_W = 48;              // Q32.16 coordinate width
   localparam int CNT_W   = 16;              // segment count width
   localparam int IDX_W   = 17;              // point index width
   localparam int TOL_W   = 24;              // tolerance width, Q8.16
   localparam int FRAC_W  = 16;              // fraction bits of coordinates
   localparam int MAG_W   = COORD_W + 2;     // magnitude of a prediction error
   localparam int ACC_W   = 2 * MAG_W + 2;   // accumulator / radicand width
   localparam int ROOT_W  = ACC_W / 2;       // root width
   localparam int REM_W   = ROOT_W + 3;      // root remainder width
   localparam int DIV_W   = IDX_W + 1;       // divider remainder width
   localparam int STEP_W  = 7;               // step counter width

   // Sentinel window: strictly between -999.01 and -998.99 in Q.16
   localparam logic signed [COORD_W-1:0] SENT_LO = COORD_W'(-64'sd65471119);
   localparam logic signed [COORD_W-1:0] SENT_HI = COORD_W'(-64'sd65469809);

   localparam logic [0:0] REG_TOLERANCE = 1'b0;
   localparam logic [0:0] REG_MAX_COUNT = 1'b1;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);
   localparam logic [CNT_W-1:0] MAX_RESET = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROOT,
      ST_DIV,
      ST_DECIDE
   } state_type;

   typedef enum logic [2:0] {
      PH_AX,
      PH_AY,
      PH_PX,
      PH_PY,
      PH_MEAN,
      PH_TOL
   } phase_type;

endpackage

// ===== hdl/grid_line_regularity_tracker_top.sv =====
// ----------------------------------------------------------------------------
// grid_line_regularity_tracker_top: regularity tracker for one grid row
// Counts regular segments along a row of Q32.16 points using a shared
// shift-add / subtract datapath under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel: one point per transaction (x, y, last_point flag).
//  - rsp_* channel: at most one transaction per row, sent when the row is
//    decided (segment_count, null_flag). Points after the decision are
//    absorbed until last_point, which rearms the tracker for the next row.
//  - csr_* channel: register writes, index 0 tolerance, index 1 max_count.
//    Always ready; write only while the tracker is idle.
// Sequencing:
//  - First two points, sentinels and absorbed points are handled in idle.
//  - Later points: two squarings and a root, two more squarings and a root,
//    a multiply, a divide, a second multiply and a decide step, all on the
//    single shift-add/subtract unit.
//  - req_ready is low while a point is in flight, and also while a result
//    sits unread in the output register.
// Reset: synchronous, active high; clears the row state and loads register
//  defaults (tolerance 1.0, max_count 65535). A pending result is dropped.
// ----------------------------------------------------------------------------
module grid_line_regularity_tracker_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [glrt_pkg::COORD_W-1:0] req_x_coord,
   input  logic signed [glrt_pkg::COORD_W-1:0] req_y_coord,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [glrt_pkg::CNT_W-1:0]   rsp_segment_count,
   output logic                                rsp_null_flag,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [0:0]                   csr_index,
   input  logic        [glrt_pkg::TOL_W-1:0]   csr_data
);

   localparam int CW = glrt_pkg::COORD_W;
   localparam int MW = glrt_pkg::MAG_W;
   localparam int AW = glrt_pkg::ACC_W;
   localparam int RW = glrt_pkg::ROOT_W;
   localparam int EW = glrt_pkg::REM_W;
   localparam int DW = glrt_pkg::DIV_W;
   localparam int IW = glrt_pkg::IDX_W;
   localparam int NW = glrt_pkg::CNT_W;
   localparam int TW = glrt_pkg::TOL_W;
   localparam int SW = glrt_pkg::STEP_W;

   // control state
   glrt_pkg::state_type state_ff, state_in;
   glrt_pkg::phase_type phase_ff, phase_in;
   logic [SW-1:0] step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] tol_ff, tol_in;
   logic [NW-1:0] max_ff, max_in;
   logic signed [CW-1:0] older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic signed [CW-1:0] newer_x_ff, newer_x_in, newer_y_ff, newer_y_in;
   logic [IW-1:0] index_ff, index_in;
   logic [CW-1:0] mean_ff, mean_in;
   logic [NW-1:0] found_ff, found_in;
   logic          decided_ff, decided_in;

   // payload / datapath
   logic signed [CW-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic          pt_last_ff, pt_last_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] mcand_ff, mcand_in;
   logic [MW-1:0] mplier_ff, mplier_in;
   logic [MW-1:0] ay_ff, ay_in, px_ff, px_in, py_ff, py_in;
   logic [EW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [DW-1:0] drem_ff, drem_in;
   logic [CW-1:0] d1_ff, d1_in;
   logic [RW-1:0] d2_ff, d2_in;
   logic [NW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_null_ff, rsp_null_in;

   // combinational helpers
   logic          accept, sentinel, emit, emit_null, emit_last, do_clear;
   logic [NW-1:0] emit_count, found_inc;
   logic signed [MW-1:0] dax, day, dpx, dpy;
   logic [AW-1:0] mul_sum;
   logic [EW-1:0] rem_sh, trial;
   logic [RW-1:0] root_nx;
   logic [DW-1:0] dcur, dvsr;
   logic          dq;
   logic [AW-1:0] lhs;
   logic          k_at_max;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == glrt_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_segment_count = rsp_count_ff;
   assign rsp_null_flag     = rsp_null_ff;

   assign sentinel = (req_x_coord >= glrt_pkg::SENT_LO) && (req_x_coord <= glrt_pkg::SENT_HI)
                  && (req_y_coord >= glrt_pkg::SENT_LO) && (req_y_coord <= glrt_pkg::SENT_HI);

   // axis differences, sign-extended so nothing saturates
   assign dax = MW'(newer_x_ff) - MW'(older_x_ff);
   assign day = MW'(newer_y_ff) - MW'(older_y_ff);
   assign dpx = dax + MW'(newer_x_ff) - MW'(req_x_coord);
   assign dpy = day + MW'(newer_y_ff) - MW'(req_y_coord);

   assign k_at_max  = ({1'b0, index_ff} >= {1'b0, IW'(max_ff)});
   assign found_inc = (found_ff == '1) ? found_ff : found_ff + NW'(1);

   // shared arithmetic: shift-add, root trial subtract, divide trial subtract
   assign mul_sum = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign rem_sh  = {rem_ff[EW-3:0], acc_ff[AW-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign root_nx = {root_ff[RW-2:0], (rem_sh >= trial)};
   assign dcur    = {drem_ff[DW-2:0], acc_ff[CW-1]};
   assign dvsr    = {1'b0, index_ff - IW'(1)};
   assign dq      = (dcur >= dvsr);
   assign lhs     = AW'({d2_ff, {glrt_pkg::FRAC_W{1'b0}}});

   always_comb begin
      state_in   = state_ff;   phase_in  = phase_ff;  step_in  = step_ff;
      tol_in     = tol_ff;     max_in    = max_ff;
      older_x_in = older_x_ff; older_y_in = older_y_ff;
      newer_x_in = newer_x_ff; newer_y_in = newer_y_ff;
      index_in   = index_ff;   mean_in   = mean_ff;   found_in = found_ff;
      decided_in = decided_ff;
      pt_x_in    = pt_x_ff;    pt_y_in   = pt_y_ff;   pt_last_in = pt_last_ff;
      acc_in     = acc_ff;     mcand_in  = mcand_ff;  mplier_in  = mplier_ff;
      ay_in      = ay_ff;      px_in     = px_ff;     py_in      = py_ff;
      rem_in     = rem_ff;     root_in   = root_ff;   drem_in    = drem_ff;
      d1_in      = d1_ff;      d2_in     = d2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_null_in  = rsp_null_ff;
      emit = 1'b0; emit_null = 1'b0; emit_last = 1'b0; do_clear = 1'b0;
      emit_count = found_ff;

      if (csr_valid) begin
         case (csr_index)
            glrt_pkg::REG_TOLERANCE: tol_in = csr_data;
            glrt_pkg::REG_MAX_COUNT: max_in = csr_data[NW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         glrt_pkg::ST_IDLE: begin
            if (accept) begin
               pt_x_in = req_x_coord; pt_y_in = req_y_coord;
               pt_last_in = req_last_point;
               emit_last  = req_last_point;
               if (decided_ff) begin
                  do_clear = req_last_point;
               end else if (sentinel) begin
                  emit = 1'b1; emit_null = 1'b1;
               end else if (index_ff == '0) begin
                  newer_x_in = req_x_coord; newer_y_in = req_y_coord;
                  index_in = IW'(1);
                  emit = req_last_point;
               end else if (index_ff == IW'(1)) begin
                  older_x_in = newer_x_ff; older_y_in = newer_y_ff;
                  newer_x_in = req_x_coord; newer_y_in = req_y_coord;
                  index_in = IW'(2);
                  emit = k_at_max || req_last_point;
               end else begin
                  // start |newer-older|^2 for x
                  ay_in = day[MW-1] ? MW'(-day) : MW'(day);
                  px_in = dpx[MW-1] ? MW'(-dpx) : MW'(dpx);
                  py_in = dpy[MW-1] ? MW'(-dpy) : MW'(dpy);
                  mplier_in = dax[MW-1] ? MW'(-dax) : MW'(dax);
                  mcand_in  = AW'(mplier_in);
                  acc_in    = '0;
                  step_in   = SW'(MW);
                  phase_in  = glrt_pkg::PH_AX;
                  state_in  = glrt_pkg::ST_MUL;
               end
            end
         end

         glrt_pkg::ST_MUL: begin
            acc_in    = mul_sum;
            mcand_in  = {mcand_ff[AW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MW-1:1]};
            step_in   = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               case (phase_ff)
                  glrt_pkg::PH_AX: begin
                     phase_in = glrt_pkg::PH_AY;
                     mcand_in = AW'(ay_ff); mplier_in = ay_ff; step_in = SW'(MW);
                  end
                  glrt_pkg::PH_PX: begin
                     phase_in = glrt_pkg::PH_PY;
                     mcand_in = AW'(py_ff); mplier_in = py_ff; step_in = SW'(MW);
                  end
                  glrt_pkg::PH_AY, glrt_pkg::PH_PY: begin
                     rem_in = '0; root_in = '0; step_in = SW'(RW);
                     state_in = glrt_pkg::ST_ROOT;
                  end
                  glrt_pkg::PH_MEAN: begin
                     drem_in = mul_sum[CW +: DW];
                     step_in = SW'(CW);
                     state_in = glrt_pkg::ST_DIV;
                  end
                  default: begin
                     state_in = glrt_pkg::ST_DECIDE;
                  end
               endcase
            end
         end

         glrt_pkg::ST_ROOT: begin
            // one result bit per step, two radicand bits shifted in
            rem_in  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
            root_in = root_nx;
            acc_in  = {acc_ff[AW-3:0], 2'b00};
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               if (phase_ff == glrt_pkg::PH_AY) begin
                  d1_in = (root_nx[RW-1:CW] != '0) ? '1 : root_nx[CW-1:0];
                  phase_in = glrt_pkg::PH_PX;
                  acc_in = '0; mcand_in = AW'(px_ff); mplier_in = px_ff;
                  step_in = SW'(MW);
               end else begin
                  // mean*i + d1, then divide by i+1
                  d2_in = root_nx;
                  phase_in = glrt_pkg::PH_MEAN;
                  acc_in = AW'(d1_ff); mcand_in = AW'(mean_ff);
                  mplier_in = MW'(index_ff - IW'(2));
                  step_in = SW'(IW);
               end
               state_in = glrt_pkg::ST_MUL;
            end
         end

         glrt_pkg::ST_DIV: begin
            drem_in = dq ? dcur - dvsr : dcur;
            acc_in[CW-1:0] = {acc_ff[CW-2:0], dq};
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               mean_in   = {acc_ff[CW-2:0], dq};
               phase_in  = glrt_pkg::PH_TOL;
               acc_in    = '0;
               mcand_in  = AW'({acc_ff[CW-2:0], dq});
               mplier_in = MW'(tol_ff);
               step_in   = SW'(TW);
               state_in  = glrt_pkg::ST_MUL;
            end
         end

         glrt_pkg::ST_DECIDE: begin
            emit_last = pt_last_ff;
            state_in  = glrt_pkg::ST_IDLE;
            if (lhs > acc_ff) begin
               emit = 1'b1;
            end else begin
               found_in = found_inc; emit_count = found_inc;
               older_x_in = newer_x_ff; older_y_in = newer_y_ff;
               newer_x_in = pt_x_ff; newer_y_in = pt_y_ff;
               index_in = index_ff + IW'(1);
               emit = k_at_max || pt_last_ff;
            end
         end

         default: state_in = glrt_pkg::ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = emit_count;
         rsp_null_in  = emit_null;
         if (emit_last) do_clear = 1'b1;
         else decided_in = 1'b1;
      end
      if (do_clear) begin
         older_x_in = '0; older_y_in = '0; newer_x_in = '0; newer_y_in = '0;
         index_in = '0; mean_in = '0; found_in = NW'(1); decided_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glrt_pkg::ST_IDLE;  phase_ff <= glrt_pkg::PH_AX;
         step_ff <= '0;                  rsp_valid_ff <= 1'b0;
         tol_ff <= glrt_pkg::TOL_RESET;  max_ff <= glrt_pkg::MAX_RESET;
         older_x_ff <= '0; older_y_ff <= '0; newer_x_ff <= '0; newer_y_ff <= '0;
         index_ff <= '0; mean_ff <= '0; found_ff <= NW'(1); decided_ff <= 1'b0;
      end else begin
         state_ff <= state_in;   phase_ff <= phase_in;   step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         tol_ff <= tol_in;       max_ff <= max_in;
         older_x_ff <= older_x_in; older_y_ff <= older_y_in;
         newer_x_ff <= newer_x_in; newer_y_ff <= newer_y_in;
         index_ff <= index_in;   mean_ff <= mean_in;     found_ff <= found_in;
         decided_ff <= decided_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff <= pt_x_in;  pt_y_ff <= pt_y_in;  pt_last_ff <= pt_last_in;
      acc_ff <= acc_in;    mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      ay_ff <= ay_in;      px_ff <= px_in;       py_ff <= py_in;
      rem_ff <= rem_in;    root_ff <= root_in;   drem_ff <= drem_in;
      d1_ff <= d1_in;      d2_ff <= d2_in;
      rsp_count_ff <= rsp_count_in; rsp_null_ff <= rsp_null_in;
   end

   // the running count never drops to zero
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      found_ff != '0) else $error("segment count reached zero");

   // divider always sees a point index of at least two (nonzero divisor)
   a_div_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == glrt_pkg::ST_DIV |-> index_ff >= IW'(2))
      else $error("divide entered with index below two");

   // a result appears only from an accepted point or the decide step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept || state_ff == glrt_pkg::ST_DECIDE))
      else $error("result raised without a source");

endmodule
